// ===== rtl/ple_pkg.sv =====
package ple_pkg;

  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int ST_W  = 2;

  // Command codes
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE     = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND_EQ    = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND_GE    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_ALL = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } ple_cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] result_value;
    logic [POS_W-1:0]        result_position;
    logic [POS_W-1:0]        entry_count;
  } ple_rsp_t;

  // Compare flags of the stored entry against the command value
  typedef struct packed {
    logic eq;
    logic ge;
  } ple_cmp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_PUT,
    S_DONE
  } ple_state_t;

endpackage

// ===== rtl/ple_store.sv =====
module ple_store import ple_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic signed [VAL_W-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic signed [VAL_W-1:0] rd_data
);

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/ple_cmp.sv =====
module ple_cmp import ple_pkg::*; (
  input  logic signed [VAL_W-1:0] entry,
  input  logic signed [VAL_W-1:0] key,
  output ple_cmp_t                flags
);

  // Shared signed compare unit
  always_comb begin
    flags.eq = (entry == key);
    flags.ge = !(entry < key);
  end

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit
// entries with 1-based positions, held in a single-port-write /
// single-port-read memory.
// Channels: cmd (valid/ready, ple_cmd_t: op, value, position) and rsp
// (valid/ready, ple_rsp_t: status, result_value, result_position,
// entry_count). Every command beat yields exactly one response beat.
// Sequence: a check state, then a walk over the memory that issues one
// read per cycle (registered read, so the walk drains the last read
// before it leaves), a put state that places the new value on insert,
// a done state that loads the response, and the idle state that takes
// the next command. The length of the walk sets how long a command
// takes.
// Throughput: one command at a time; cmd_ready is high only while idle.
// A finished response sits in the output register, and the next command
// is taken and worked on while it waits; a stalled receiver holds the
// block only when a second response is ready to load.
// Reset: clears the entry count and all handshake state; memory contents
// are left as they are and are never read before being written.
module positional_list_engine_unit import ple_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  ple_cmd_t cmd,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output ple_rsp_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  ple_state_t state, state_next;

  // Latched command
  logic [OP_W-1:0]         op_q;
  logic signed [VAL_W-1:0] val_q;
  logic [POS_W-1:0]        pos_q;

  // Walk control
  logic [AW-1:0] idx;
  logic [AW-1:0] lim;
  logic          more;
  logic          rd_vld;
  logic [AW-1:0] rd_addr_q;
  logic          found;

  // Result being built
  logic [ST_W-1:0]         status_q;
  logic signed [VAL_W-1:0] rval_q;
  logic [POS_W-1:0]        rpos_q;
  logic [CW-1:0]           res_cnt;
  logic [CW-1:0]           count;

  // Memory port
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic signed [VAL_W-1:0] rd_data;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_data;

  ple_cmp_t cmp;

  // Decode results of the check cycle
  logic [ST_W-1:0] chk_status;
  logic [CW-1:0]   chk_cnt;
  logic [AW-1:0]   chk_idx;
  logic [AW-1:0]   chk_lim;
  logic            chk_walk;
  logic            chk_put;

  // Walk decisions
  logic walk_down;
  logic hit;
  logic take_hit;
  logic take_val;
  logic keep;
  logic more_next;
  logic rsp_load;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] pos_m1;
  logic [AW-1:0] pos_idx;
  logic [AW-1:0] last_idx;

  ple_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ple_cmp u_cmp (
    .entry (rd_data),
    .key   (val_q),
    .flags (cmp)
  );

  assign cmd_ready = (state == S_IDLE);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || rsp_ready);

  assign pos_x    = XW'(pos_q);
  assign cnt_x    = XW'(count);
  assign pos_m1   = pos_x - XW'(1);
  assign pos_idx  = AW'(pos_m1);
  assign last_idx = AW'(count - CW'(1));

  // Check cycle: validate the position (insert, delete, read) and set up the walk range
  always_comb begin
    chk_status = ST_OK;
    chk_cnt    = count;
    chk_idx    = '0;
    chk_lim    = last_idx;
    chk_walk   = 1'b0;
    chk_put    = 1'b0;
    unique case (op_q) inside
      OP_INSERT: begin
        if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
          chk_status = ST_BADPOS;
        end else if (count == CW'(CAPACITY)) begin
          chk_status = ST_FULL;
        end else begin
          chk_cnt  = count + CW'(1);
          chk_idx  = last_idx;
          chk_lim  = pos_idx;
          chk_walk = (pos_x <= cnt_x);
          chk_put  = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          chk_status = ST_BADPOS;
        end else begin
          chk_cnt  = count - CW'(1);
          chk_idx  = pos_idx;
          chk_walk = 1'b1;
        end
      end
      OP_FIND_EQ, OP_FIND_GE: begin
        chk_status = ST_NOTFOUND;
        chk_walk   = (count != '0);
      end
      OP_READ: begin
        if (pos_x == '0 || pos_x > cnt_x) begin
          chk_status = ST_BADPOS;
        end else begin
          chk_idx  = pos_idx;
          chk_lim  = pos_idx;
          chk_walk = 1'b1;
        end
      end
      OP_REMOVE_ALL: begin
        chk_cnt  = '0;
        chk_walk = (count != '0);
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (chk_walk) begin
          state_next = S_WALK;
        end else if (chk_put) begin
          state_next = S_PUT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WALK: begin
        if (!more && !rd_vld) begin
          state_next = (op_q == OP_INSERT) ? S_PUT : S_DONE;
        end
      end
      S_PUT: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Memory port and walk decisions
  always_comb begin
    walk_down = (op_q == OP_INSERT);
    hit       = (op_q == OP_FIND_EQ) ? cmp.eq : cmp.ge;
    rd_en     = 1'b0;
    rd_addr   = idx;
    wr_en     = 1'b0;
    wr_addr   = rd_addr_q;
    wr_data   = rd_data;
    take_hit  = 1'b0;
    take_val  = 1'b0;
    keep      = 1'b0;
    more_next = more;
    unique case (state)
      S_WALK: begin
        rd_en = more;
        if (rd_vld) begin
          unique case (op_q) inside
            OP_INSERT: begin
              wr_en   = 1'b1;
              wr_addr = rd_addr_q + AW'(1);
            end
            OP_DELETE: begin
              if (rd_addr_q == pos_idx) begin
                take_val = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_addr = rd_addr_q - AW'(1);
              end
            end
            OP_FIND_EQ, OP_FIND_GE: begin
              take_hit = hit && !found;
            end
            OP_READ: begin
              take_val = 1'b1;
            end
            OP_REMOVE_ALL: begin
              keep    = !cmp.eq;
              wr_en   = keep;
              wr_addr = AW'(res_cnt);
            end
            default: begin
            end
          endcase
        end
        more_next = more && (idx != lim) && !take_hit;
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_idx;
        wr_data = val_q;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      more      <= 1'b0;
      rd_vld    <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (state == S_CHECK) begin
        more <= chk_walk;
      end else if (state == S_WALK) begin
        more <= more_next;
      end
      if (rsp_load) begin
        count     <= res_cnt;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_addr_q <= idx;
    if (cmd_valid && cmd_ready) begin
      op_q     <= cmd.op;
      val_q    <= cmd.value;
      pos_q    <= cmd.position;
      status_q <= ST_OK;
      rval_q   <= '0;
      rpos_q   <= '0;
      found    <= 1'b0;
    end
    if (state == S_CHECK) begin
      status_q <= chk_status;
      res_cnt  <= chk_cnt;
      idx      <= chk_idx;
      lim      <= chk_lim;
    end
    if (state == S_WALK) begin
      if (more) begin
        idx <= walk_down ? (idx - AW'(1)) : (idx + AW'(1));
      end
      if (take_val) begin
        rval_q <= rd_data;
      end
      if (take_hit) begin
        found    <= 1'b1;
        status_q <= ST_OK;
        rpos_q   <= POS_W'(CW'(rd_addr_q) + CW'(1));
      end
      if (keep) begin
        res_cnt <= res_cnt + CW'(1);
      end
    end
    if (rsp_load) begin
      rsp.status          <= status_q;
      rsp.result_value    <= rval_q;
      rsp.result_position <= rpos_q;
      rsp.entry_count     <= POS_W'(res_cnt);
    end
  end

  // Assertions
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CW'(wr_addr) < CW'(CAPACITY)))
    else $error("memory write outside capacity");

  a_rd_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == S_WALK))
    else $error("read data pending outside the walk");

  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> (state == S_CHECK))
    else $error("accepted command not checked");

  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> (rsp_valid && state == S_IDLE))
    else $error("response not presented after load");

endmodule
